FILE: rtl/core/lzpd_pkg.sv
`timescale 1ns / 1ps

package lzpd_pkg;

  // bytes packed into one result item
  localparam int BEAT_BYTES = 4;
  localparam int BEAT_IDX_W = 2;
  localparam int BYTE_CNT_W = 3;

  // saturating count of produced bytes
  localparam int PROD_CNT_W = 9;
  localparam logic [PROD_CNT_W-1:0] PROD_CNT_LIMIT = 9'd256;

  // one byte or terminator handed from the copy sequencer to the beat packer
  typedef struct packed {
    logic       valid;
    logic       has_byte;
    logic [7:0] data;
    logic       last;
    logic       bad;
  } lzpd_evt_t;

endpackage

FILE: rtl/core/lzpd_ifs.sv
`timescale 1ns / 1ps

interface lzpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_offset;
  logic [7:0] token_byte;

  modport source (output valid, output token_offset, output token_byte, input ready);
  modport sink   (input valid, input token_offset, input token_byte, output ready);
endinterface

interface lzpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] byte_count;
  logic       last_beat;
  logic       bad_offset;

  modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                  output out_byte3, output byte_count, output last_beat,
                  output bad_offset, input ready);
  modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
                  input out_byte3, input byte_count, input last_beat,
                  input bad_offset, output ready);
endinterface

FILE: rtl/core/lzpd_hist_mem.sv
`timescale 1ns / 1ps

module lzpd_hist_mem #(
  parameter int HISTORY_DEPTH = 256,
  localparam int AW = $clog2(HISTORY_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [HISTORY_DEPTH];
  logic [7:0] rdata_r;

  // read-before-write on a same-address collision; sequencer forwards
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/lzpd_copy_seq.sv
`timescale 1ns / 1ps

module lzpd_copy_seq #(
  parameter int HISTORY_DEPTH = 256,
  localparam int AW = $clog2(HISTORY_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_valid,
  input  logic [7:0]          tok_offset,
  input  logic [7:0]          tok_byte,
  output logic                tok_ready,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [7:0]          mem_rdata,
  input  logic                pk_ready,
  output lzpd_pkg::lzpd_evt_t evt
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DISP = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;

  localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] PTR_TOP = AW'(HISTORY_DEPTH - 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == PTR_TOP) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]                       state_r, state_nxt;
  logic [AW-1:0]                    wp_r, wp_nxt;
  logic [lzpd_pkg::PROD_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]                       remain_r, remain_nxt;
  logic                             arr_v_r, arr_v_nxt;
  logic                             skid_v_r, skid_v_nxt;

  logic [7:0]    off_r, off_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic          arr_last_r, arr_last_nxt;
  logic          fwd_r, fwd_nxt;
  logic [7:0]    fwd_data_r, fwd_data_nxt;
  logic [7:0]    skid_b_r, skid_b_nxt;
  logic          skid_last_r, skid_last_nxt;

  logic [7:0]    arr_byte;
  logic [AW-1:0] src_start;
  logic          issue;
  logic          wr_bump;

  always_comb begin
    arr_byte = fwd_r ? fwd_data_r : mem_rdata;
    if (wp_r >= AW'(off_r)) begin
      src_start = wp_r - AW'(off_r);
    end else begin
      src_start = AW'({1'b0, wp_r} + DEPTH_W - (AW+1)'(off_r));
    end

    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    remain_nxt    = remain_r;
    skid_v_nxt    = skid_v_r;
    off_nxt       = off_r;
    len_nxt       = len_r;
    src_nxt       = src_r;
    skid_b_nxt    = skid_b_r;
    skid_last_nxt = skid_last_r;

    tok_ready = (state_r == ST_IDLE);
    evt       = '0;
    mem_we    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = arr_byte;
    mem_re    = 1'b0;
    mem_raddr = src_r;
    wr_bump   = 1'b0;
    issue     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (tok_valid) begin
          off_nxt   = tok_offset;
          len_nxt   = tok_byte;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        if (off_r == 8'd0) begin
          // literal
          evt = '{valid: 1'b1, has_byte: 1'b1, data: len_r, last: 1'b1, bad: 1'b0};
          if (pk_ready) begin
            mem_we    = 1'b1;
            mem_wdata = len_r;
            wr_bump   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if ({1'b0, off_r} > cnt_r) begin
          // reaches behind the produced history
          evt = '{valid: 1'b1, has_byte: 1'b0, data: 8'd0, last: 1'b1, bad: 1'b1};
          if (pk_ready) begin
            state_nxt = ST_IDLE;
          end
        end else if (len_r == 8'd0) begin
          evt = '{valid: 1'b1, has_byte: 1'b0, data: 8'd0, last: 1'b1, bad: 1'b0};
          if (pk_ready) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          src_nxt    = src_start;
          remain_nxt = len_r;
          state_nxt  = ST_COPY;
        end
      end
      ST_COPY: begin
        issue = (remain_r != 8'd0) && pk_ready && !skid_v_r;
        if ((remain_r == 8'd0) && !arr_v_r && !skid_v_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // returning copy byte: always written back, held in the skid if the packer stalls
    if (arr_v_r) begin
      mem_we  = 1'b1;
      wr_bump = 1'b1;
    end
    if (skid_v_r) begin
      evt = '{valid: 1'b1, has_byte: 1'b1, data: skid_b_r, last: skid_last_r, bad: 1'b0};
      if (pk_ready) begin
        skid_v_nxt = 1'b0;
      end
    end else if (arr_v_r) begin
      evt = '{valid: 1'b1, has_byte: 1'b1, data: arr_byte, last: arr_last_r, bad: 1'b0};
      if (!pk_ready) begin
        skid_v_nxt    = 1'b1;
        skid_b_nxt    = arr_byte;
        skid_last_nxt = arr_last_r;
      end
    end

    if (issue) begin
      mem_re     = 1'b1;
      src_nxt    = ptr_inc(src_r);
      remain_nxt = remain_r - 8'd1;
    end
    arr_v_nxt    = issue;
    arr_last_nxt = (remain_r == 8'd1);
    // read of the slot being written this cycle sees old data: forward instead
    fwd_nxt      = issue && arr_v_r && (src_r == wp_r);
    fwd_data_nxt = arr_byte;

    if (wr_bump) begin
      wp_nxt = ptr_inc(wp_r);
      if (cnt_r != lzpd_pkg::PROD_CNT_LIMIT) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wp_r     <= '0;
      cnt_r    <= '0;
      remain_r <= '0;
      arr_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      cnt_r    <= cnt_nxt;
      remain_r <= remain_nxt;
      arr_v_r  <= arr_v_nxt;
      skid_v_r <= skid_v_nxt;
      fwd_r    <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r       <= off_nxt;
    len_r       <= len_nxt;
    src_r       <= src_nxt;
    arr_last_r  <= arr_last_nxt;
    fwd_data_r  <= fwd_data_nxt;
    skid_b_r    <= skid_b_nxt;
    skid_last_r <= skid_last_nxt;
  end

endmodule

FILE: rtl/core/lzpd_beat_pack.sv
`timescale 1ns / 1ps

module lzpd_beat_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  lzpd_pkg::lzpd_evt_t evt,
  output logic                pk_ready,
  lzpd_out_if.source          out_beat
);

  localparam int NB = lzpd_pkg::BEAT_BYTES;
  localparam int IW = lzpd_pkg::BEAT_IDX_W;
  localparam int CW = lzpd_pkg::BYTE_CNT_W;

  logic [IW-1:0]         fill_r, fill_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [NB-1:0][7:0]    asm_r, asm_nxt;
  logic [NB-1:0][7:0]    ob_r, ob_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  last_r, last_nxt;
  logic                  bad_r, bad_nxt;
  logic [NB-1:0][7:0]    merged;
  logic                  take;

  always_comb begin
    pk_ready = !out_v_r || out_beat.ready;
    take     = evt.valid && pk_ready;

    merged         = asm_r;
    merged[fill_r] = evt.data;

    fill_nxt  = fill_r;
    asm_nxt   = asm_r;
    ob_nxt    = ob_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    bad_nxt   = bad_r;
    out_v_nxt = out_v_r && !out_beat.ready;

    if (take) begin
      if (evt.has_byte) begin
        if ((fill_r == IW'(NB - 1)) || evt.last) begin
          ob_nxt    = merged;
          cnt_nxt   = CW'(fill_r) + 1'b1;
          last_nxt  = evt.last;
          bad_nxt   = 1'b0;
          out_v_nxt = 1'b1;
          asm_nxt   = '0;
          fill_nxt  = '0;
        end else begin
          asm_nxt  = merged;
          fill_nxt = fill_r + 1'b1;
        end
      end else begin
        // empty terminator: error or zero-length copy
        ob_nxt    = '0;
        cnt_nxt   = '0;
        last_nxt  = 1'b1;
        bad_nxt   = evt.bad;
        out_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      asm_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      asm_r   <= asm_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r   <= ob_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_beat.valid      = out_v_r;
  assign out_beat.out_byte0  = ob_r[0];
  assign out_beat.out_byte1  = ob_r[1];
  assign out_beat.out_byte2  = ob_r[2];
  assign out_beat.out_byte3  = ob_r[3];
  assign out_beat.byte_count = cnt_r;
  assign out_beat.last_beat  = last_r;
  assign out_beat.bad_offset = bad_r;

endmodule

FILE: rtl/core/lz_pair_decompressor_unit.sv
`timescale 1ns / 1ps

// byte-oriented lz77 decompressor. each input item is a token of two bytes: an offset of
// zero makes the second byte a literal, which is emitted and appended to history; a
// nonzero offset copies token_byte bytes from that distance back, overlap allowed. output
// items carry up to four bytes, and the final item of a token has last_beat set. an offset
// larger than the bytes produced so far (count saturates at 256) gives one item with
// bad_offset set and no bytes; a zero-length copy gives one empty last item. the history
// lives in a single-port-read ring memory with a registered read, so copies run one byte
// per clock while the output is not stalled; the input is held until the whole token
// has been handed to the packer. a finished item waiting in the output register stalls the
// byte work until it is taken. history needs no clearing after reset since reads never
// reach unwritten slots.
module lz_pair_decompressor_unit #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  lzpd_in_if.sink    in_tok,
  lzpd_out_if.source out_beat
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  // history ring port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // sequencer to packer
  lzpd_pkg::lzpd_evt_t evt;
  logic                pk_ready;

  lzpd_hist_mem #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // token decode, history pointers and the copy read/write-back loop
  lzpd_copy_seq #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (in_tok.valid),
    .tok_offset (in_tok.token_offset),
    .tok_byte   (in_tok.token_byte),
    .tok_ready  (in_tok.ready),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .pk_ready   (pk_ready),
    .evt        (evt)
  );

  // packs bytes into result items, holds the output register
  lzpd_beat_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt      (evt),
    .pk_ready (pk_ready),
    .out_beat (out_beat)
  );

endmodule

FILE: rtl/core/lzpd_checker.sv
`timescale 1ns / 1ps

module lzpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte0,
  input logic [7:0] out_byte3,
  input logic [2:0] out_byte_count,
  input logic       out_last_beat,
  input logic       out_bad_offset
);

  // reset leaves no result pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid right after reset");

  // a stalled item keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte0) && $stable(out_byte3)
      && $stable(out_byte_count) && $stable(out_last_beat))
    else $error("stalled result item changed");

  // only the final item of a token may be short
  a_full_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_beat |-> out_byte_count == 3'(lzpd_pkg::BEAT_BYTES))
    else $error("non-final item not full");

  // an error item is a lone, empty final item
  a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_offset |-> out_last_beat && (out_byte_count == 3'd0))
    else $error("malformed error item");

endmodule

bind lz_pair_decompressor_unit lzpd_checker u_lzpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_beat.valid),
  .out_ready      (out_beat.ready),
  .out_byte0      (out_beat.out_byte0),
  .out_byte3      (out_beat.out_byte3),
  .out_byte_count (out_beat.byte_count),
  .out_last_beat  (out_beat.last_beat),
  .out_bad_offset (out_beat.bad_offset)
);
